@@ rtl/rpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_pkg
// Shared types and constants of the raster pit finder.
// ----------------------------------------------------------------------------
package rpf_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // register index, taken from address bit 2
    localparam logic REG_FRAME_COLS = 1'b0;
    localparam logic REG_FRAME_ROWS = 1'b1;

    localparam logic [12:0] FRAME_COLS_RESET = 13'd4096;
    localparam logic [14:0] FRAME_ROWS_RESET = 15'd16384;
    localparam logic [14:0] ROWS_MAX         = 15'd16384;
    localparam int          DIM_MIN          = 3;

    // stream widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 88;
    localparam int RES_W      = 84;

    localparam int OUT_FIFO_DEPTH = 4;

    // one pit report, row in the lowest bits
    typedef struct packed {
        logic [25:0]        pit_number;
        logic signed [31:0] pit_elev;
        logic [11:0]        pit_col;
        logic [13:0]        pit_row;
    } pit_result_t;

endpackage

@@ rtl/rpf_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_cfg
// APB register file for the frame size, with clamped working values.
// ----------------------------------------------------------------------------
module rpf_cfg
    import rpf_pkg::*;
#(
    parameter int MAX_COLS = 4096,
    parameter int COLS_W   = 13
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [COLS_W-1:0]     cols_eff,
    output logic [14:0]           rows_eff
);

    localparam int CMP_W = (COLS_W > 13) ? COLS_W : 13;

    logic [12:0]      frame_cols_reg;
    logic [14:0]      frame_rows_reg;
    logic             wr_en;
    logic [CMP_W-1:0] cols_raw;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cols_reg <= FRAME_COLS_RESET;
            frame_rows_reg <= FRAME_ROWS_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_FRAME_COLS: frame_cols_reg <= pwdata[12:0];
                REG_FRAME_ROWS: frame_rows_reg <= pwdata[14:0];
                default:        ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (paddr[2])
            REG_FRAME_COLS: prdata = CFG_DATA_W'(frame_cols_reg);
            REG_FRAME_ROWS: prdata = CFG_DATA_W'(frame_rows_reg);
            default:        prdata = '0;
        endcase
    end

    // clamp columns into 3..MAX_COLS
    assign cols_raw = CMP_W'(frame_cols_reg);
    always_comb
    begin
        if (cols_raw < CMP_W'(DIM_MIN))
            cols_eff = COLS_W'(DIM_MIN);
        else if (cols_raw > CMP_W'(MAX_COLS))
            cols_eff = COLS_W'(MAX_COLS);
        else
            cols_eff = COLS_W'(cols_raw);
    end

    // clamp rows into 3..16384
    always_comb
    begin
        if (frame_rows_reg < 15'(DIM_MIN))
            rows_eff = 15'(DIM_MIN);
        else if (frame_rows_reg > ROWS_MAX)
            rows_eff = ROWS_MAX;
        else
            rows_eff = frame_rows_reg;
    end

endmodule

@@ rtl/rpf_line_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_line_mem
// Line buffer memory: upper and middle row side by side, one write port and
// one registered read port.
// ----------------------------------------------------------------------------
module rpf_line_mem
#(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 12
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/rpf_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_core
// Raster counters, line buffer read/modify/write, 3x3 window and pit test.
// ----------------------------------------------------------------------------
module rpf_core
    import rpf_pkg::*;
#(
    parameter int MAX_COLS  = 4096,
    parameter int ELEV_BITS = 32,
    parameter int COL_W     = 12,
    parameter int COLS_W    = 13
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [ELEV_BITS-1:0]   elev_in,
    input  logic [COLS_W-1:0]      cols_eff,
    input  logic [14:0]            rows_eff,
    output logic                   mem_rd_en,
    output logic [COL_W-1:0]       mem_rd_addr,
    input  logic [2*ELEV_BITS-1:0] mem_rd_data,
    output logic                   mem_wr_en,
    output logic [COL_W-1:0]       mem_wr_addr,
    output logic [2*ELEV_BITS-1:0] mem_wr_data,
    output logic                   busy,
    output logic                   res_valid,
    output pit_result_t            res
);

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [13:0]      row_reg;
    logic [13:0]      row_next;
    logic             row_end;
    logic             frame_end;

    logic                        s1_valid_reg;
    logic                        s1_test_reg;
    logic                        s1_frame_end_reg;
    logic signed [ELEV_BITS-1:0] s1_x_reg;
    logic [COL_W-1:0]            s1_col_reg;
    logic [13:0]                 s1_row_reg;

    logic signed [ELEV_BITS-1:0] w_reg [6];
    logic signed [ELEV_BITS-1:0] up;
    logic signed [ELEV_BITS-1:0] mid;
    logic signed [ELEV_BITS-1:0] ctr;
    logic                        pit;

    logic [25:0] pit_cnt_reg;
    logic [25:0] pit_cnt_next;

    // position of the incoming sample and its wrap points
    assign row_end   = (COLS_W'(col_reg) + 1'b1) >= cols_eff;
    assign frame_end = row_end && (({1'b0, row_reg} + 1'b1) >= rows_eff);

    always_comb
    begin
        col_next = row_end ? '0 : COL_W'(col_reg + 1'b1);
        if (!row_end)
            row_next = row_reg;
        else if (frame_end)
            row_next = '0;
        else
            row_next = row_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // fetch the two stored rows of this column
    assign mem_rd_en   = accept;
    assign mem_rd_addr = col_reg;

    // stage 1 request state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_test_reg      <= (row_reg >= 14'd2) && (col_reg >= COL_W'(2));
            s1_frame_end_reg <= frame_end;
            s1_x_reg         <= $signed(elev_in);
            s1_col_reg       <= col_reg;
            s1_row_reg       <= row_reg;
        end
    end

    assign busy = s1_valid_reg;

    // neighborhood: stored rows and the incoming sample
    assign up  = $signed(mem_rd_data[2*ELEV_BITS-1:ELEV_BITS]);
    assign mid = $signed(mem_rd_data[ELEV_BITS-1:0]);
    assign ctr = w_reg[1*3+1];

    assign pit = s1_test_reg
              && (w_reg[0] >= ctr) && (w_reg[1] >= ctr) && (w_reg[2] >= ctr)
              && (w_reg[3] >= ctr) && (w_reg[5] >= ctr)
              && (up >= ctr) && (mid >= ctr) && (s1_x_reg >= ctr);

    // write back the shifted column: middle moves up, new sample goes in
    assign mem_wr_en   = s1_valid_reg;
    assign mem_wr_addr = s1_col_reg;
    assign mem_wr_data = {mid, s1_x_reg};

    // window shift, one column per request
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            w_reg[0] <= w_reg[3];
            w_reg[1] <= w_reg[4];
            w_reg[2] <= w_reg[5];
            w_reg[3] <= up;
            w_reg[4] <= mid;
            w_reg[5] <= s1_x_reg;
        end
    end

    // running pit number, saturating, cleared at frame end
    always_comb
    begin
        pit_cnt_next = pit_cnt_reg;
        if (pit && !(&pit_cnt_reg))
            pit_cnt_next = pit_cnt_reg + 1'b1;
        if (s1_frame_end_reg)
            pit_cnt_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pit_cnt_reg <= '0;
        else if (s1_valid_reg)
            pit_cnt_reg <= pit_cnt_next;
    end

    // result of this request
    assign res_valid      = s1_valid_reg && pit;
    assign res.pit_row    = s1_row_reg - 1'b1;
    assign res.pit_col    = 12'(s1_col_reg - 1'b1);
    assign res.pit_elev   = 32'(ctr);
    assign res.pit_number = pit_cnt_reg;

endmodule

@@ rtl/rpf_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_out_fifo
// Result queue in front of the output stream; reserves room for the
// request still in the pipeline.
// ----------------------------------------------------------------------------
module rpf_out_fifo
    import rpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  pit_result_t push_data,
    input  logic        pending,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output pit_result_t out_data
);

    localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    pit_result_t      entry_reg [OUT_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // a request accepted now pushes in the cycle after the one in flight
    assign room = (CNT_W'(count_reg + CNT_W'(pending))) < CNT_W'(OUT_FIFO_DEPTH);

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

endmodule

@@ rtl/raster_pit_finder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_pit_finder
// Streaming 3x3 pit detector over a raster of signed elevations.
// ----------------------------------------------------------------------------
// Samples enter on the s_ stream in row-major order, one per request. When
// the sample at (r,c) with r,c >= 2 arrives, the cell at (r-1,c-1) is tested
// and, if none of its eight neighbors is lower, a pit report leaves on the
// m_ stream: row, column, elevation and the running pit number of the frame.
// Border cells never produce a report. frame_cols and frame_rows are set
// over the APB port; the user must do so only while the block is idle,
// which the block itself does not enforce. Throughput is one sample per
// cycle while s_tready is high: the line buffer memory is read when a sample
// is accepted and written back with the shifted column in the next cycle, so
// each column sees one read and one write per row. Each report passes
// stage 1 and a four-entry result queue, which decouples the output; when
// the receiver stalls the queue fills and s_tready drops once it holds no
// room for the request in flight and one more.
// Reset clears the counters, the queue and the registers (4096 columns,
// 16384 rows); the line buffers are not cleared, which is harmless since
// every entry is written in the first two rows before it is tested.
// ----------------------------------------------------------------------------
module raster_pit_finder
    import rpf_pkg::*;
#(
    parameter int MAX_COLS  = 4096,
    parameter int ELEV_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // elevation [31:0]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // pit_row [13:0], pit_col [25:14], pit_elev [57:26], pit_number [83:58]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int COLS_W = $clog2(MAX_COLS + 1);
    localparam int LINE_W = 2 * ELEV_BITS;

    logic [COLS_W-1:0] cols_eff;
    logic [14:0]       rows_eff;
    logic              accept;
    logic              room;
    logic              busy;
    logic              mem_rd_en;
    logic [COL_W-1:0]  mem_rd_addr;
    logic [LINE_W-1:0] mem_rd_data;
    logic              mem_wr_en;
    logic [COL_W-1:0]  mem_wr_addr;
    logic [LINE_W-1:0] mem_wr_data;
    logic              res_valid;
    pit_result_t       res;
    pit_result_t       out_res;

    assign s_tready = room;
    assign accept   = s_tvalid && s_tready;
    assign m_tdata  = OUT_DATA_W'(out_res);

    // configuration registers
    rpf_cfg #(
        .MAX_COLS (MAX_COLS),
        .COLS_W   (COLS_W)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cols_eff (cols_eff),
        .rows_eff (rows_eff)
    );

    // line buffers
    rpf_line_mem #(
        .DEPTH  (MAX_COLS),
        .WIDTH  (LINE_W),
        .ADDR_W (COL_W)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // window and pit test
    rpf_core #(
        .MAX_COLS  (MAX_COLS),
        .ELEV_BITS (ELEV_BITS),
        .COL_W     (COL_W),
        .COLS_W    (COLS_W)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .elev_in     (s_tdata[ELEV_BITS-1:0]),
        .cols_eff    (cols_eff),
        .rows_eff    (rows_eff),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .busy        (busy),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result queue
    rpf_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pending   (busy),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

endmodule

@@ rtl/rpf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_checker
// Port-level checks of the pit finder, bound to the top level.
// ----------------------------------------------------------------------------
module rpf_checker
    import rpf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [CFG_ADDR_W-1:0] paddr,
    input logic [CFG_DATA_W-1:0] pwdata,
    input logic [CFG_DATA_W-1:0] prdata,
    input logic                  pready
);

    // a stalled report holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("pit report changed while stalled");

    // border cells in row 0 and column 0 are never reported
    a_no_border: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13:0] != 14'd0) && (m_tdata[25:14] != 12'd0))
        else $error("pit reported on the frame border");

    // a report out of an empty queue follows an accepted sample through stage 1 and the queue
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("pit report without a matching sample");

    // no wait states on reads or writes
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable |-> pready)
        else $error("configuration access stalled");

endmodule

bind raster_pit_finder rpf_checker u_rpf_checker (.*);
